// ===== rtl/ddfp_pkg.sv =====
`default_nettype none

package ddfp_pkg;

    localparam int TIME_WIDTH_DEFAULT  = 48;
    localparam int COUNT_WIDTH_DEFAULT = 32;

    localparam int PERIOD_W    = 24;
    localparam int ELAPSED_W   = 16;
    localparam int PROD_W      = PERIOD_W + ELAPSED_W;
    localparam int ROUND_SHIFT = 8;
    localparam int STEP_W      = PROD_W - ROUND_SHIFT;
    localparam int MCNT_W      = $clog2(ELAPSED_W + 1);
    localparam int ALPHA_BITS  = 16;
    localparam int ALPHA_W     = ALPHA_BITS + 1;
    localparam int CFG_IDX_W   = 1;

    localparam logic [PERIOD_W-1:0] SIM_PERIOD_DEFAULT     = 24'd16683;
    localparam logic [PERIOD_W-1:0] PRESENT_PERIOD_DEFAULT = 24'd16667;
    localparam logic [PROD_W-1:0]   ROUND_HALF             = PROD_W'(1) << (ROUND_SHIFT - 1);
    localparam logic [ALPHA_W-1:0]  ALPHA_ONE              = ALPHA_W'(1) << ALPHA_BITS;

    localparam logic [1:0] REQ_QUERY   = 2'd0;
    localparam logic [1:0] REQ_SIM     = 2'd1;
    localparam logic [1:0] REQ_PRESENT = 2'd2;
    localparam logic [1:0] REQ_RESTART = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_SIM_PERIOD     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESENT_PERIOD = 1'd1;

    typedef struct packed {
        logic start;
        logic short_run;
    } ddfp_div_req_t;

endpackage

`default_nettype wire

// ===== rtl/ddfp_serdiv.sv =====
`default_nettype none

module ddfp_serdiv #(
    parameter int DIVIDEND_W = ddfp_pkg::TIME_WIDTH_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire ddfp_pkg::ddfp_div_req_t       req,
    input  wire logic [DIVIDEND_W-1:0]         dividend,
    input  wire logic [ddfp_pkg::PERIOD_W-1:0] rem_init,
    input  wire logic [ddfp_pkg::PERIOD_W-1:0] divisor,
    output logic                               done,
    output logic [DIVIDEND_W-1:0]              quotient,
    output logic [ddfp_pkg::PERIOD_W-1:0]      remainder
);
    import ddfp_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [PERIOD_W-1:0]   rem_reg, rem_next;
    logic [PERIOD_W-1:0]   div_reg, div_next;
    logic [PERIOD_W:0]     trial;
    logic [PERIOD_W:0]     trial_sub;
    logic                  trial_ge;

    // one restoring step per cycle, quotient bits shift in behind the dividend
    assign trial     = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign trial_ge  = trial >= {1'b0, div_reg};
    assign trial_sub = trial - {1'b0, div_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            quo_next  = dividend;
            rem_next  = rem_init;
            div_next  = divisor;
            cnt_next  = req.short_run ? CNT_W'(ALPHA_BITS) : CNT_W'(DIVIDEND_W);
        end
        else if (busy_reg)
        begin
            rem_next = trial_ge ? trial_sub[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
            quo_next = {quo_reg[DIVIDEND_W-2:0], trial_ge};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            quo_reg  <= '0;
            rem_reg  <= '0;
            div_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            quo_reg  <= quo_next;
            rem_reg  <= rem_next;
            div_reg  <= div_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ===== rtl/dual_deadline_frame_pacer.sv =====
// Transaction time is set by the bit-serial 16-step multiplier and the shared
// one-bit-per-cycle divider.
// One transaction at a time; the next is taken the cycle after the result enters the output
// register.
// Reset (async, active low) zeroes deadlines and counters and loads default periods.
`default_nettype none

module dual_deadline_frame_pacer #(
    parameter int TIME_WIDTH  = ddfp_pkg::TIME_WIDTH_DEFAULT,
    parameter int COUNT_WIDTH = ddfp_pkg::COUNT_WIDTH_DEFAULT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_wr_en,
    input  wire logic [ddfp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ddfp_pkg::PERIOD_W-1:0]  cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [1:0]                     req_type,
    input  wire logic [TIME_WIDTH-1:0]          now,
    input  wire logic                           keep_phase,
    input  wire logic [ddfp_pkg::ELAPSED_W-1:0] frame_periods,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic                                sim_due,
    output logic                                present_due,
    output logic [ddfp_pkg::ALPHA_W-1:0]        alpha,
    output logic [TIME_WIDTH-1:0]               next_deadline,
    output logic [COUNT_WIDTH-1:0]              missed_now,
    output logic [COUNT_WIDTH-1:0]              missed_total,
    output logic [COUNT_WIDTH-1:0]              sim_frames,
    output logic [COUNT_WIDTH-1:0]              present_frames
);
    import ddfp_pkg::*;

    localparam int SUM_W = ((TIME_WIDTH > STEP_W) ? TIME_WIDTH : STEP_W) + 1;
    localparam int SAT_W = (TIME_WIDTH > COUNT_WIDTH) ? TIME_WIDTH : COUNT_WIDTH;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RESTART,
        ST_MUL,
        ST_ROUND,
        ST_SDL,
        ST_SUPD,
        ST_PPREP,
        ST_PDIV,
        ST_PUPD1,
        ST_PUPD2,
        ST_APREP,
        ST_ACHK,
        ST_ADIV,
        ST_OUT
    } state_t;

    function automatic logic [TIME_WIDTH-1:0] sat_add(
        input logic [SUM_W-1:0] a,
        input logic [SUM_W-1:0] b
    );
        logic [SUM_W-1:0] s;
        s = a + b;
        return ((s >> TIME_WIDTH) != '0) ? '1 : s[TIME_WIDTH-1:0];
    endfunction

    state_t                 state_reg, state_next;
    logic [PERIOD_W-1:0]    sim_period_reg, sim_period_next;
    logic [PERIOD_W-1:0]    present_period_reg, present_period_next;
    logic [TIME_WIDTH-1:0]  now_reg, now_next;
    logic                   keep_reg, keep_next;
    logic [PROD_W-1:0]      prod_reg, prod_next;
    logic [MCNT_W-1:0]      mcnt_reg, mcnt_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic [TIME_WIDTH-1:0]  dl_reg, dl_next;
    logic [TIME_WIDTH-1:0]  alt_reg, alt_next;
    logic [TIME_WIDTH-1:0]  pbase_reg, pbase_next;
    logic [COUNT_WIDTH-1:0] missed_reg, missed_next;
    logic [TIME_WIDTH-1:0]  sim_dl_reg, sim_dl_next;
    logic [TIME_WIDTH-1:0]  pres_dl_reg, pres_dl_next;
    logic [COUNT_WIDTH-1:0] sim_cnt_reg, sim_cnt_next;
    logic [COUNT_WIDTH-1:0] pres_cnt_reg, pres_cnt_next;
    logic [COUNT_WIDTH-1:0] miss_cnt_reg, miss_cnt_next;
    logic                   sdue_reg, sdue_next;
    logic                   pdue_reg, pdue_next;
    logic [TIME_WIDTH-1:0]  diff_reg, diff_next;
    logic [TIME_WIDTH-1:0]  ndl_reg, ndl_next;
    logic [ALPHA_W-1:0]     alpha_reg, alpha_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   out_sdue_reg, out_sdue_next;
    logic                   out_pdue_reg, out_pdue_next;
    logic [ALPHA_W-1:0]     out_alpha_reg, out_alpha_next;
    logic [TIME_WIDTH-1:0]  out_ndl_reg, out_ndl_next;
    logic [COUNT_WIDTH-1:0] out_missed_reg, out_missed_next;
    logic [COUNT_WIDTH-1:0] out_mtot_reg, out_mtot_next;
    logic [COUNT_WIDTH-1:0] out_sfr_reg, out_sfr_next;
    logic [COUNT_WIDTH-1:0] out_pfr_reg, out_pfr_next;

    logic [PERIOD_W-1:0]    sp;
    logic [PERIOD_W-1:0]    pp;
    logic [PERIOD_W:0]      mul_sum;
    logic [PROD_W-1:0]      prod_rnd;
    logic [SAT_W-1:0]       quo_ext;
    logic [COUNT_WIDTH:0]   miss_sum;

    ddfp_div_req_t          div_req;
    logic [TIME_WIDTH-1:0]  div_dividend;
    logic [PERIOD_W-1:0]    div_rem_init;
    logic [PERIOD_W-1:0]    div_divisor;
    logic                   div_done;
    logic [TIME_WIDTH-1:0]  div_quo;
    logic [PERIOD_W-1:0]    div_rem;

    assign sp = (sim_period_reg == '0) ? SIM_PERIOD_DEFAULT : sim_period_reg;
    assign pp = (present_period_reg == '0) ? PRESENT_PERIOD_DEFAULT : present_period_reg;

    // shift-add multiply: add the period into the high part when the low bit is set
    assign mul_sum  = {1'b0, prod_reg[PROD_W-1:ELAPSED_W]} + (prod_reg[0] ? {1'b0, sp} : '0);
    assign prod_rnd = prod_reg + ROUND_HALF;
    assign quo_ext  = SAT_W'(div_quo);
    assign miss_sum = {1'b0, miss_cnt_reg} + {1'b0, missed_reg};

    ddfp_serdiv #(
        .DIVIDEND_W (TIME_WIDTH)
    ) u_ddfp_serdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (div_req),
        .dividend  (div_dividend),
        .rem_init  (div_rem_init),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_comb
    begin
        state_next          = state_reg;
        sim_period_next     = sim_period_reg;
        present_period_next = present_period_reg;
        now_next            = now_reg;
        keep_next           = keep_reg;
        prod_next           = prod_reg;
        mcnt_next           = mcnt_reg;
        step_next           = step_reg;
        dl_next             = dl_reg;
        alt_next            = alt_reg;
        pbase_next          = pbase_reg;
        missed_next         = missed_reg;
        sim_dl_next         = sim_dl_reg;
        pres_dl_next        = pres_dl_reg;
        sim_cnt_next        = sim_cnt_reg;
        pres_cnt_next       = pres_cnt_reg;
        miss_cnt_next       = miss_cnt_reg;
        sdue_next           = sdue_reg;
        pdue_next           = pdue_reg;
        diff_next           = diff_reg;
        ndl_next            = ndl_reg;
        alpha_next          = alpha_reg;
        out_valid_next      = out_valid_reg;
        out_sdue_next       = out_sdue_reg;
        out_pdue_next       = out_pdue_reg;
        out_alpha_next      = out_alpha_reg;
        out_ndl_next        = out_ndl_reg;
        out_missed_next     = out_missed_reg;
        out_mtot_next       = out_mtot_reg;
        out_sfr_next        = out_sfr_reg;
        out_pfr_next        = out_pfr_reg;
        div_req             = '0;
        div_dividend        = '0;
        div_rem_init        = '0;
        div_divisor         = sp;

        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_SIM_PERIOD:     sim_period_next = cfg_data;
                CFG_PRESENT_PERIOD: present_period_next = cfg_data;
                default:            ;
            endcase
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    now_next    = now;
                    keep_next   = keep_phase;
                    prod_next   = PROD_W'(frame_periods);
                    mcnt_next   = MCNT_W'(ELAPSED_W);
                    missed_next = '0;
                    case (req_type)
                        REQ_QUERY:   state_next = ST_APREP;
                        REQ_SIM:     state_next = ST_MUL;
                        REQ_PRESENT: state_next = ST_PPREP;
                        REQ_RESTART: state_next = ST_RESTART;
                        default:     state_next = ST_APREP;
                    endcase
                end
            end
            ST_RESTART:
            begin
                sim_dl_next   = now_reg;
                pres_dl_next  = now_reg;
                sim_cnt_next  = '0;
                pres_cnt_next = '0;
                miss_cnt_next = '0;
                state_next    = ST_APREP;
            end
            ST_MUL:
            begin
                prod_next = {mul_sum, prod_reg[ELAPSED_W-1:1]};
                mcnt_next = mcnt_reg - MCNT_W'(1);
                if (mcnt_reg == MCNT_W'(1))
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                step_next  = prod_rnd[PROD_W-1:ROUND_SHIFT];
                state_next = ST_SDL;
            end
            ST_SDL:
            begin
                dl_next    = sat_add(SUM_W'(sim_dl_reg), SUM_W'(step_reg));
                alt_next   = sat_add(SUM_W'(now_reg), SUM_W'(sp));
                state_next = ST_SUPD;
            end
            ST_SUPD:
            begin
                sim_dl_next  = (keep_reg || now_reg <= dl_reg) ? dl_reg : alt_reg;
                sim_cnt_next = sim_cnt_reg + COUNT_WIDTH'(1);
                state_next   = ST_APREP;
            end
            ST_PPREP:
            begin
                div_req.start     = 1'b1;
                div_req.short_run = 1'b0;
                div_divisor       = pp;
                if (now_reg > pres_dl_reg)
                begin
                    div_dividend = now_reg - pres_dl_reg;
                    pbase_next   = now_reg;
                end
                else
                begin
                    div_dividend = '0;
                    pbase_next   = pres_dl_reg;
                end
                state_next = ST_PDIV;
            end
            ST_PDIV:
            begin
                if (div_done)
                begin
                    state_next = ST_PUPD1;
                end
            end
            ST_PUPD1:
            begin
                // deadline + skipped * period equals the overdue base minus the remainder
                missed_next = ((quo_ext >> COUNT_WIDTH) != '0) ? '1 : COUNT_WIDTH'(quo_ext);
                pbase_next  = pbase_reg - TIME_WIDTH'(div_rem);
                state_next  = ST_PUPD2;
            end
            ST_PUPD2:
            begin
                miss_cnt_next = miss_sum[COUNT_WIDTH] ? '1 : miss_sum[COUNT_WIDTH-1:0];
                pres_dl_next  = sat_add(SUM_W'(pbase_reg), SUM_W'(pp));
                pres_cnt_next = pres_cnt_reg + COUNT_WIDTH'(1);
                state_next    = ST_APREP;
            end
            ST_APREP:
            begin
                sdue_next  = now_reg >= sim_dl_reg;
                pdue_next  = now_reg >= pres_dl_reg;
                diff_next  = sim_dl_reg - now_reg;
                ndl_next   = (sim_dl_reg < pres_dl_reg) ? sim_dl_reg : pres_dl_reg;
                state_next = ST_ACHK;
            end
            ST_ACHK:
            begin
                if (sdue_reg)
                begin
                    alpha_next = ALPHA_ONE;
                    state_next = ST_OUT;
                end
                else if (diff_reg >= TIME_WIDTH'(sp))
                begin
                    alpha_next = '0;
                    state_next = ST_OUT;
                end
                else
                begin
                    div_req.start     = 1'b1;
                    div_req.short_run = 1'b1;
                    div_rem_init      = sp - diff_reg[PERIOD_W-1:0];
                    div_divisor       = sp;
                    state_next        = ST_ADIV;
                end
            end
            ST_ADIV:
            begin
                if (div_done)
                begin
                    alpha_next = ALPHA_W'(div_quo[ALPHA_BITS-1:0]);
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_sdue_next   = sdue_reg;
                    out_pdue_next   = pdue_reg;
                    out_alpha_next  = alpha_reg;
                    out_ndl_next    = ndl_reg;
                    out_missed_next = missed_reg;
                    out_mtot_next   = miss_cnt_reg;
                    out_sfr_next    = sim_cnt_reg;
                    out_pfr_next    = pres_cnt_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            sim_period_reg     <= SIM_PERIOD_DEFAULT;
            present_period_reg <= PRESENT_PERIOD_DEFAULT;
            now_reg            <= '0;
            keep_reg           <= 1'b0;
            prod_reg           <= '0;
            mcnt_reg           <= '0;
            step_reg           <= '0;
            dl_reg             <= '0;
            alt_reg            <= '0;
            pbase_reg          <= '0;
            missed_reg         <= '0;
            sim_dl_reg         <= '0;
            pres_dl_reg        <= '0;
            sim_cnt_reg        <= '0;
            pres_cnt_reg       <= '0;
            miss_cnt_reg       <= '0;
            sdue_reg           <= 1'b0;
            pdue_reg           <= 1'b0;
            diff_reg           <= '0;
            ndl_reg            <= '0;
            alpha_reg          <= '0;
            out_valid_reg      <= 1'b0;
            out_sdue_reg       <= 1'b0;
            out_pdue_reg       <= 1'b0;
            out_alpha_reg      <= '0;
            out_ndl_reg        <= '0;
            out_missed_reg     <= '0;
            out_mtot_reg       <= '0;
            out_sfr_reg        <= '0;
            out_pfr_reg        <= '0;
        end
        else
        begin
            state_reg          <= state_next;
            sim_period_reg     <= sim_period_next;
            present_period_reg <= present_period_next;
            now_reg            <= now_next;
            keep_reg           <= keep_next;
            prod_reg           <= prod_next;
            mcnt_reg           <= mcnt_next;
            step_reg           <= step_next;
            dl_reg             <= dl_next;
            alt_reg            <= alt_next;
            pbase_reg          <= pbase_next;
            missed_reg         <= missed_next;
            sim_dl_reg         <= sim_dl_next;
            pres_dl_reg        <= pres_dl_next;
            sim_cnt_reg        <= sim_cnt_next;
            pres_cnt_reg       <= pres_cnt_next;
            miss_cnt_reg       <= miss_cnt_next;
            sdue_reg           <= sdue_next;
            pdue_reg           <= pdue_next;
            diff_reg           <= diff_next;
            ndl_reg            <= ndl_next;
            alpha_reg          <= alpha_next;
            out_valid_reg      <= out_valid_next;
            out_sdue_reg       <= out_sdue_next;
            out_pdue_reg       <= out_pdue_next;
            out_alpha_reg      <= out_alpha_next;
            out_ndl_reg        <= out_ndl_next;
            out_missed_reg     <= out_missed_next;
            out_mtot_reg       <= out_mtot_next;
            out_sfr_reg        <= out_sfr_next;
            out_pfr_reg        <= out_pfr_next;
        end
    end

    assign in_stall       = (state_reg != ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign sim_due        = out_sdue_reg;
    assign present_due    = out_pdue_reg;
    assign alpha          = out_alpha_reg;
    assign next_deadline  = out_ndl_reg;
    assign missed_now     = out_missed_reg;
    assign missed_total   = out_mtot_reg;
    assign sim_frames     = out_sfr_reg;
    assign present_frames = out_pfr_reg;

endmodule

`default_nettype wire

// ===== rtl/ddfp_checker.sv =====
`default_nettype none

module ddfp_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           in_valid,
    input wire logic                           in_stall,
    input wire logic                           out_valid,
    input wire logic                           out_stall,
    input wire logic                           sim_due,
    input wire logic [ddfp_pkg::ALPHA_W-1:0]   alpha
);
    import ddfp_pkg::*;

    // one transaction in flight: taking an item closes the input side
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall
    ) else $error("input taken while a transaction is in flight");

    a_out_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(alpha) && $stable(sim_due))
    ) else $error("stalled result changed");

    a_alpha_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> (alpha <= ALPHA_ONE)
    ) else $error("alpha above one");

    a_alpha_due: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> (sim_due == (alpha == ALPHA_ONE))
    ) else $error("alpha and sim_due disagree");

endmodule

bind dual_deadline_frame_pacer ddfp_checker u_ddfp_checker (.*);

`default_nettype wire

// ===== sim/dual_deadline_frame_pacer_test.sv =====
`default_nettype none

module dual_deadline_frame_pacer_test;

    import ddfp_pkg::*;

    localparam int TW = TIME_WIDTH_DEFAULT;
    localparam int CW = COUNT_WIDTH_DEFAULT;
    localparam logic [63:0] TMAX = 64'hFFFF_FFFF_FFFF;
    localparam logic [63:0] CMAX = 64'hFFFF_FFFF;
    localparam int QUIET_LIMIT = 4000;

    typedef struct packed {
        logic              sim_due;
        logic              present_due;
        logic [ALPHA_W-1:0] alpha;
        logic [TW-1:0]     next_deadline;
        logic [CW-1:0]     missed_now;
        logic [CW-1:0]     missed_total;
        logic [CW-1:0]     sim_frames;
        logic [CW-1:0]     present_frames;
    } pace_result_t;

    class pacing_tracker;
        logic [63:0] sim_period;
        logic [63:0] present_period;
        logic [63:0] sim_dl;
        logic [63:0] present_dl;
        logic [63:0] sim_cnt;
        logic [63:0] present_cnt;
        logic [63:0] missed_cnt;
        pace_result_t due_results[$];
        int errors;

        function new();
            sim_period = SIM_PERIOD_DEFAULT;
            present_period = PRESENT_PERIOD_DEFAULT;
            sim_dl = 0;
            present_dl = 0;
            sim_cnt = 0;
            present_cnt = 0;
            missed_cnt = 0;
            errors = 0;
        endfunction

        function logic [63:0] sim_span();
            return (sim_period == 0) ? 64'(SIM_PERIOD_DEFAULT) : sim_period;
        endfunction

        function logic [63:0] present_span();
            return (present_period == 0) ? 64'(PRESENT_PERIOD_DEFAULT) : present_period;
        endfunction

        function logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
            logic [63:0] s;
            s = a + b;
            if (s < a || s > TMAX)
                return TMAX;
            return s;
        endfunction

        function void set_period(logic [CFG_IDX_W-1:0] idx, logic [PERIOD_W-1:0] value);
            if (idx == CFG_SIM_PERIOD)
                sim_period = 64'(value);
            else if (idx == CFG_PRESENT_PERIOD)
                present_period = 64'(value);
        endfunction

        function void take_event(logic [1:0] kind, logic [63:0] stamp, logic keep,
                                 logic [63:0] periods);
            logic [63:0] sp;
            logic [63:0] pp;
            logic [63:0] step;
            logic [63:0] dl;
            logic [63:0] overdue;
            logic [63:0] skipped;
            logic [63:0] missed;
            logic [63:0] a;
            logic [63:0] diff;
            pace_result_t r;
            sp = sim_span();
            pp = present_span();
            missed = 0;
            if (kind == REQ_SIM)
            begin
                step = (periods * sp + 64'd128) >> 8;
                dl = sat_add(sim_dl, step);
                sim_dl = (keep || stamp <= dl) ? dl : sat_add(stamp, sp);
                sim_cnt = (sim_cnt + 1) & CMAX;
            end
            else if (kind == REQ_PRESENT)
            begin
                overdue = (stamp > present_dl) ? stamp - present_dl : 0;
                skipped = overdue / pp;
                missed = (skipped > CMAX) ? CMAX : skipped;
                missed_cnt = (missed_cnt > CMAX - missed) ? CMAX : missed_cnt + missed;
                present_dl = sat_add(present_dl + skipped * pp, pp);
                present_cnt = (present_cnt + 1) & CMAX;
            end
            else if (kind == REQ_RESTART)
            begin
                sim_dl = stamp;
                present_dl = stamp;
                sim_cnt = 0;
                present_cnt = 0;
                missed_cnt = 0;
            end
            if (stamp >= sim_dl)
                a = 64'd65536;
            else
            begin
                diff = sim_dl - stamp;
                a = (diff >= sp) ? 0 : ((sp - diff) << 16) / sp;
            end
            r.sim_due = (stamp >= sim_dl);
            r.present_due = (stamp >= present_dl);
            r.alpha = a[ALPHA_W-1:0];
            r.next_deadline = (sim_dl < present_dl) ? sim_dl[TW-1:0] : present_dl[TW-1:0];
            r.missed_now = missed[CW-1:0];
            r.missed_total = missed_cnt[CW-1:0];
            r.sim_frames = sim_cnt[CW-1:0];
            r.present_frames = present_cnt[CW-1:0];
            due_results.push_back(r);
        endfunction

        function void compare(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void match_result(pace_result_t got);
            pace_result_t want;
            if (due_results.size() == 0)
            begin
                $error("result transaction with nothing expected");
                errors++;
                return;
            end
            want = due_results.pop_front();
            compare("sim_due", 64'(want.sim_due), 64'(got.sim_due));
            compare("present_due", 64'(want.present_due), 64'(got.present_due));
            compare("alpha", 64'(want.alpha), 64'(got.alpha));
            compare("next_deadline", 64'(want.next_deadline), 64'(got.next_deadline));
            compare("missed_now", 64'(want.missed_now), 64'(got.missed_now));
            compare("missed_total", 64'(want.missed_total), 64'(got.missed_total));
            compare("sim_frames", 64'(want.sim_frames), 64'(got.sim_frames));
            compare("present_frames", 64'(want.present_frames), 64'(got.present_frames));
        endfunction

        function int pending();
            return due_results.size();
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_SIM_PERIOD;
    logic [PERIOD_W-1:0]  cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [1:0]           req_type = REQ_QUERY;
    logic [TW-1:0]        now = '0;
    logic                 keep_phase = 1'b0;
    logic [ELAPSED_W-1:0] frame_periods = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic                 sim_due;
    logic                 present_due;
    logic [ALPHA_W-1:0]   alpha;
    logic [TW-1:0]        next_deadline;
    logic [CW-1:0]        missed_now;
    logic [CW-1:0]        missed_total;
    logic [CW-1:0]        sim_frames;
    logic [CW-1:0]        present_frames;

    pacing_tracker tracker = new();
    int idle_pct = 26;
    logic [63:0] cursor = 0;

    dual_deadline_frame_pacer dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .req_type(req_type),
        .now(now),
        .keep_phase(keep_phase),
        .frame_periods(frame_periods),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .sim_due(sim_due),
        .present_due(present_due),
        .alpha(alpha),
        .next_deadline(next_deadline),
        .missed_now(missed_now),
        .missed_total(missed_total),
        .sim_frames(sim_frames),
        .present_frames(present_frames)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    task automatic put_event(logic [1:0] kind, logic [63:0] stamp, logic keep,
                             logic [15:0] periods);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= kind;
        now <= stamp[TW-1:0];
        keep_phase <= keep;
        frame_periods <= periods;
        do
            @(posedge clk);
        while (in_stall);
        tracker.take_event(kind, stamp & TMAX, keep, 64'(periods));
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (tracker.pending() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_periods(logic [PERIOD_W-1:0] sim_value,
                                 logic [PERIOD_W-1:0] present_value);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_SIM_PERIOD;
        cfg_data <= sim_value;
        @(posedge clk);
        cfg_index <= CFG_PRESENT_PERIOD;
        cfg_data <= present_value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        tracker.set_period(CFG_SIM_PERIOD, sim_value);
        tracker.set_period(CFG_PRESENT_PERIOD, present_value);
    endtask

    task automatic run_random(int count, int calm_from, int calm_to);
        int r;
        int t;
        int e;
        logic [1:0] kind;
        logic [63:0] stamp;
        logic [63:0] pp;
        logic [15:0] periods;
        for (int i = 0; i < count; i++)
        begin
            idle_pct = (i >= calm_from && i < calm_to) ? 0 : 26;
            pp = tracker.present_span();
            r = $urandom_range(99);
            if (r < 12)
                kind = REQ_QUERY;
            else if (r < 50)
                kind = REQ_SIM;
            else if (r < 88)
                kind = REQ_PRESENT;
            else
                kind = REQ_RESTART;
            if (cursor > (TMAX >> 1))
                cursor = 64'($urandom_range(0, 1 << 20));
            t = $urandom_range(99);
            if (t < 70 || (kind == REQ_RESTART && t < 85))
            begin
                cursor += 64'($urandom_range(0, 32'(2 * pp)));
                if ($urandom_range(9) == 0)
                    cursor += pp * 64'($urandom_range(0, 64));
                stamp = cursor;
            end
            else if (t < 80)
                stamp = (cursor > pp) ? cursor - 64'($urandom_range(0, 32'(pp))) : cursor;
            else if (t < 93)
                stamp = {$urandom, $urandom} & TMAX;
            else
                stamp = TMAX - 64'($urandom_range(0, 32'(3 * pp)));
            e = $urandom_range(9);
            if (e < 6)
                periods = 16'($urandom_range(200, 320));
            else if (e < 8)
                periods = 16'($urandom_range(0, 65535));
            else if (e == 8)
                periods = 16'd0;
            else
                periods = 16'hFFFF;
            put_event(kind, stamp, 1'($urandom_range(1)), periods);
        end
        idle_pct = 26;
    endtask

    // result side: random stall, check every transaction
    initial
    begin
        pace_result_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                got.sim_due = sim_due;
                got.present_due = present_due;
                got.alpha = alpha;
                got.next_deadline = next_deadline;
                got.missed_now = missed_now;
                got.missed_total = missed_total;
                got.sim_frames = sim_frames;
                got.present_frames = present_frames;
                tracker.match_result(got);
            end
            out_stall <= (idle_pct > 0) && ($urandom_range(99) < idle_pct);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        settle();

        // power-up defaults, deadlines at zero
        put_event(REQ_QUERY, 0, 1'b0, 16'd0);
        put_event(REQ_RESTART, 1000, 1'b0, 16'd0);
        put_event(REQ_QUERY, 900, 1'b1, 16'd256);
        put_event(REQ_SIM, 1000, 1'b0, 16'd256);
        put_event(REQ_QUERY, 17682, 1'b0, 16'd0);
        // late frame, debt dropped then kept
        put_event(REQ_SIM, 100000, 1'b0, 16'd256);
        put_event(REQ_SIM, 500000, 1'b1, 16'd256);
        // rounding of the scaled step
        put_event(REQ_SIM, 0, 1'b1, 16'd128);
        put_event(REQ_SIM, 0, 1'b1, 16'd1);
        put_event(REQ_SIM, 0, 1'b1, 16'd0);
        put_event(REQ_SIM, 0, 1'b0, 16'hFFFF);
        put_event(REQ_PRESENT, 1000, 1'b0, 16'd0);
        put_event(REQ_PRESENT, 100000, 1'b0, 16'd0);
        put_event(REQ_PRESENT, 0, 1'b0, 16'd0);
        // time saturation
        put_event(REQ_SIM, TMAX, 1'b1, 16'hFFFF);
        put_event(REQ_RESTART, TMAX, 1'b0, 16'd0);
        put_event(REQ_PRESENT, TMAX, 1'b0, 16'd0);
        put_event(REQ_SIM, TMAX, 1'b0, 16'd256);

        // unit periods: counter saturation
        write_periods(24'd1, 24'd1);
        put_event(REQ_RESTART, 0, 1'b0, 16'd0);
        put_event(REQ_PRESENT, 64'hFFFF_FFFE, 1'b0, 16'd0);
        put_event(REQ_PRESENT, 64'h1_0000_0009, 1'b0, 16'd0);
        put_event(REQ_PRESENT, TMAX, 1'b0, 16'd0);
        put_event(REQ_SIM, 5, 1'b0, 16'hFFFF);

        // zero period falls back to the default
        write_periods(24'd0, 24'd0);
        put_event(REQ_RESTART, 50, 1'b0, 16'd0);
        put_event(REQ_SIM, 40000, 1'b0, 16'd256);
        put_event(REQ_PRESENT, 70000, 1'b1, 16'd0);

        write_periods(SIM_PERIOD_DEFAULT, PRESENT_PERIOD_DEFAULT);
        cursor = 0;
        run_random(110, 30, 90);
        write_periods(24'd1, 24'd3);
        cursor = 0;
        run_random(110, 0, 0);
        write_periods(24'hFFFFFF, 24'hFFFFFF);
        cursor = 0;
        run_random(110, 0, 0);
        write_periods(24'd0, 24'd0);
        cursor = 0;
        run_random(110, 0, 0);
        write_periods(24'($urandom_range(2, 50000)), 24'($urandom_range(2, 50000)));
        cursor = 0;
        run_random(110, 0, 0);

        settle();
        repeat (80) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
